FILE: hdl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg: shared types and constants of the PUCT child selector
// Sizes, fixed-point constants, datapath command and status structures.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int MAX_CHILDREN = 256;
    localparam int IDX_W        = $clog2(MAX_CHILDREN);
    localparam int CNT_W        = $clog2(MAX_CHILDREN) + 1;

    localparam logic [32:0] PB_C_BASE  = 33'd19652;
    localparam logic [15:0] LN2_Q16    = 16'd45426;
    localparam logic [31:0] VISIT_MAX  = 32'hFFFF_FFFF;
    localparam logic [31:0] SCORE_MAX  = 32'h7FFF_FFFF;

    // configuration register indexes
    localparam logic CFG_EXPLORE_INIT = 1'b0;
    localparam logic CFG_CHILD_COUNT  = 1'b1;

    // item modes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_VLOSS  = 2'd1;
    localparam logic [1:0] MODE_SELECT = 2'd2;

    // log2 in unsigned Q6.16, evaluated at elaboration for the base constant
    function automatic logic [21:0] log2_q16_f(input logic [32:0] v);
        logic [63:0] m;
        logic [5:0]  ip;
        logic [15:0] frac;
        ip   = 6'd0;
        frac = 16'd0;
        for (int k = 0; k < 33; k++)
        begin
            if (v[k])
                ip = 6'(k);
        end
        if (ip >= 6'd31)
            m = 64'(v) >> (ip - 6'd31);
        else
            m = 64'(v) << (6'd31 - ip);
        for (int k = 0; k < 16; k++)
        begin
            m    = (m * m) >> 31;
            frac = {frac[14:0], 1'b0};
            if (m >= 64'h1_0000_0000)
            begin
                frac[0] = 1'b1;
                m       = m >> 1;
            end
        end
        return {ip[5:0], frac};
    endfunction

    localparam logic [21:0] LOG2_BASE_Q16 = log2_q16_f(PB_C_BASE);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD,
        OP_VL_READ,
        OP_VL_START,
        OP_VL_WRITE,
        OP_LOG_NORM,
        OP_LOG_SQ,
        OP_LOG_RED,
        OP_C_MUL,
        OP_C_ADD,
        OP_READ,
        OP_SEL_START,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_MUL2
    } dp_op_t;

    typedef struct packed {
        dp_op_t             op;
        logic [IDX_W-1:0]   addr;
        logic               first;
        logic               score;
        logic               emit;
        logic               empty;
    } dp_cmd_t;

    typedef struct packed {
        logic               log_top;
        logic               div_done;
        logic               vl_zero;
        logic [CNT_W-1:0]   scan_len;
    } dp_stat_t;

endpackage

FILE: hdl/puct_child_selector_unit.sv
// ----------------------------------------------------------------------------
// puct_child_selector_unit: PUCT child selection with virtual loss
// Per-child tables of one search-tree node; load, virtual loss and scan.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  item in   start, busy               mode, child_index, prior,
//                                      total_value, vloss_visits
//  result    result_strobe             found, chosen_child, best_score
//  config    cfg_write                 cfg_index, cfg_data
//
//  After the accepting edge busy stays high through S_LOAD for a load, and
//  through S_VL_READ, S_VL_START and S_VL_WAIT for a virtual loss, waiting
//  there on the shared divider; S_VL_WAIT is skipped when the child is left
//  with no visits. Select keeps busy high while the log2 is normalised and
//  reduced by repeated squaring, then per child in use through the read, the
//  divider, the square root and the score; an empty scan goes through S_EMPTY
//  only. No clearing pass after reset: the table valid bits clear at once.
//  Results are strobed for one cycle and cannot be held off; busy falls in
//  the cycle the strobe is shown.
// ----------------------------------------------------------------------------
module puct_child_selector_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          mode,
    input  logic [7:0]          child_index,
    input  logic [15:0]         prior,
    input  logic signed [31:0]  total_value,
    input  logic [7:0]          vloss_visits,
    output logic                result_strobe,
    output logic                found,
    output logic [7:0]          chosen_child,
    output logic signed [31:0]  best_score,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data
);
    import pcs_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pcs_controller u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .mode          (mode),
        .stat          (stat),
        .cmd           (cmd),
        .busy          (busy),
        .result_strobe (result_strobe)
    );

    pcs_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .child_index  (child_index[IDX_W-1:0]),
        .prior        (prior),
        .total_value  (total_value),
        .vloss_visits (vloss_visits),
        .found        (found),
        .chosen_child (chosen_child),
        .best_score   (best_score)
    );

endmodule

FILE: hdl/pcs_divider.sv
// ----------------------------------------------------------------------------
// pcs_divider: shared restoring divider
// Unsigned 64 by 33 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcs_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [32:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    import pcs_pkg::*;

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] q_reg, q_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] dvs_reg, dvs_next;
    logic [33:0] rem_sh;

    // one restoring step
    always_comb
    begin
        run_next  = run_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg, q_reg[63]};
        if (start)
        begin
            run_next  = 1'b1;
            done_next = 1'b0;
            cnt_next  = 6'd0;
            q_next    = dividend;
            rem_next  = 33'd0;
            dvs_next  = divisor;
        end
        else if (run_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = 33'(rem_sh - {1'b0, dvs_reg});
                q_next   = {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[32:0];
                q_next   = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: hdl/pcs_datapath.sv
// ----------------------------------------------------------------------------
// pcs_datapath: child tables and arithmetic of the selector
// Per-child memories, parent visits, log2, square root and score logic.
// ----------------------------------------------------------------------------
module pcs_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pcs_pkg::dp_cmd_t        cmd,
    output pcs_pkg::dp_stat_t       stat,
    input  logic                    cfg_write,
    input  logic                    cfg_index,
    input  logic [15:0]             cfg_data,
    input  logic [pcs_pkg::IDX_W-1:0] child_index,
    input  logic [15:0]             prior,
    input  logic signed [31:0]      total_value,
    input  logic [7:0]              vloss_visits,
    output logic                    found,
    output logic [7:0]              chosen_child,
    output logic signed [31:0]      best_score
);
    import pcs_pkg::*;

    // child tables
    logic [15:0]        prior_mem [MAX_CHILDREN];
    logic signed [31:0] total_mem [MAX_CHILDREN];
    logic [31:0]        visit_mem [MAX_CHILDREN];
    logic signed [31:0] mean_mem  [MAX_CHILDREN];
    logic [MAX_CHILDREN-1:0] valid_reg;

    // configuration and parent
    logic [15:0]        explore_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [31:0]        parent_reg;

    // captured item
    logic [IDX_W-1:0]   idx_reg;
    logic [15:0]        prior_reg;
    logic signed [31:0] total_reg;
    logic [7:0]         vl_reg;

    // registered reads
    logic [IDX_W-1:0]   rd_addr;
    logic [15:0]        prior_rd_reg;
    logic signed [31:0] total_rd_reg;
    logic [31:0]        visit_rd_reg;
    logic signed [31:0] mean_rd_reg;
    logic               vld_rd_reg;

    // log2 and exploration factor
    logic [32:0]        lt_reg;
    logic [5:0]         ip_reg;
    logic [31:0]        lm_reg;
    logic [63:0]        lprod_reg;
    logic [15:0]        frac_reg;
    logic [37:0]        lgm_reg;
    logic [24:0]        c_reg;

    // per child
    logic [24:0]        cp_reg;
    logic [63:0]        sx_reg;
    logic [63:0]        sr_reg;
    logic [63:0]        sb_reg;
    logic [40:0]        u_reg;
    logic signed [31:0] best_reg;
    logic [IDX_W-1:0]   best_i_reg;

    // result registers
    logic               found_reg;
    logic [7:0]         chosen_child_reg;
    logic signed [31:0] best_score_reg;

    logic               div_start;
    logic [63:0]        div_dividend;
    logic [32:0]        div_divisor;
    logic               div_done;
    logic [63:0]        div_q;

    logic [31:0]        visit_eff;
    logic [32:0]        visit_sum;
    logic [31:0]        visit_new;
    logic [31:0]        parent_new;
    logic [32:0]        parent_sum;
    logic [31:0]        total_mag;
    logic signed [31:0] mean_new;
    logic signed [31:0] mean_eff;
    logic [32:0]        lt_init;
    logic [32:0]        p31;
    logic [21:0]        la;
    logic [21:0]        lg;
    logic [63:0]        sq_trial;
    logic signed [42:0] s_wide;
    logic signed [31:0] s_sat;

    // visit update and mean sign handling
    assign visit_eff  = vld_rd_reg ? visit_rd_reg : 32'd0;
    assign visit_sum  = {1'b0, visit_eff} + 33'(vl_reg);
    assign visit_new  = visit_sum[32] ? VISIT_MAX : visit_sum[31:0];
    assign parent_sum = {1'b0, parent_reg} + 33'(vl_reg);
    assign parent_new = parent_sum[32] ? VISIT_MAX : parent_sum[31:0];
    assign total_mag  = total_rd_reg[31] ? 32'(-total_rd_reg) : total_rd_reg;
    assign mean_new   = total_rd_reg[31] ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);
    assign mean_eff   = vld_rd_reg ? mean_rd_reg : 32'sd0;

    // log2 argument, reduction and difference
    assign lt_init = {1'b0, parent_reg} + PB_C_BASE + 33'd1;
    assign p31     = lprod_reg[63:31];
    assign la      = {ip_reg, frac_reg};
    assign lg      = (la > LOG2_BASE_Q16) ? 22'(la - LOG2_BASE_Q16) : 22'd0;

    // square root trial and saturated score
    assign sq_trial = sr_reg + sb_reg;
    assign s_wide   = 43'(mean_eff) + $signed({2'b00, u_reg});
    assign s_sat    = (s_wide > 43'sd2147483647) ? $signed(SCORE_MAX) : s_wide[31:0];

    // divider operands
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = {parent_reg, 32'd0};
        div_divisor  = {1'b0, visit_eff} + 33'd1;
        case (cmd.op)
            OP_VL_START:
            begin
                div_start    = (visit_new != 32'd0);
                div_dividend = {32'd0, total_mag};
                div_divisor  = {1'b0, visit_new};
            end
            OP_SEL_START:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    pcs_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign rd_addr = (cmd.op == OP_READ) ? cmd.addr : idx_reg;

    // memory writes and registered reads
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                prior_mem[idx_reg] <= prior_reg;
                total_mem[idx_reg] <= total_reg;
                visit_mem[idx_reg] <= 32'd0;
                mean_mem[idx_reg]  <= 32'sd0;
            end
            OP_VL_START:
            begin
                visit_mem[idx_reg] <= visit_new;
                if (visit_new == 32'd0)
                    mean_mem[idx_reg] <= 32'sd0;
            end
            OP_VL_WRITE:
            begin
                mean_mem[idx_reg] <= mean_new;
            end
            default:
            begin
            end
        endcase
        if (cmd.op == OP_READ || cmd.op == OP_VL_READ)
        begin
            prior_rd_reg <= prior_mem[rd_addr];
            total_rd_reg <= total_mem[rd_addr];
            visit_rd_reg <= visit_mem[rd_addr];
            mean_rd_reg  <= mean_mem[rd_addr];
            vld_rd_reg   <= valid_reg[rd_addr];
        end
    end

    // control state: configuration, parent visits, valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            explore_reg <= 16'd640;
            count_reg   <= '0;
            parent_reg  <= 32'd1;
            valid_reg   <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == CFG_EXPLORE_INIT)
                explore_reg <= cfg_data;
            if (cfg_write && cfg_index == CFG_CHILD_COUNT)
                count_reg <= cfg_data[CNT_W-1:0];
            if (cmd.op == OP_LOAD)
            begin
                valid_reg[idx_reg] <= 1'b1;
                if (idx_reg == '0)
                    parent_reg <= 32'd1;
            end
            if (cmd.op == OP_VL_START)
            begin
                valid_reg[idx_reg] <= 1'b1;
                parent_reg         <= parent_new;
            end
        end
    end

    // item capture, log2, exploration and scoring
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                idx_reg   <= child_index;
                prior_reg <= prior;
                total_reg <= total_value;
                vl_reg    <= vloss_visits;
                lt_reg    <= lt_init;
                ip_reg    <= 6'd32;
                frac_reg  <= 16'd0;
                // mantissa when the leading one is already at the top
                lm_reg    <= lt_init[32:1];
            end
            OP_LOG_NORM:
            begin
                lt_reg <= {lt_reg[31:0], 1'b0};
                ip_reg <= ip_reg - 6'd1;
                lm_reg <= lt_reg[31:0];
            end
            OP_LOG_SQ:
            begin
                lprod_reg <= 64'(lm_reg) * 64'(lm_reg);
            end
            OP_LOG_RED:
            begin
                frac_reg <= {frac_reg[14:0], p31[32]};
                lm_reg   <= p31[32] ? p31[32:1] : p31[31:0];
            end
            OP_C_MUL:
            begin
                lgm_reg <= 38'(lg) * 38'(LN2_Q16);
            end
            OP_C_ADD:
            begin
                c_reg <= 25'(lgm_reg >> 16) + {1'b0, explore_reg, 8'd0};
            end
            OP_SEL_START:
            begin
                cp_reg <= 25'((41'(c_reg) * 41'(prior_rd_reg)) >> 16);
            end
            OP_SQRT_INIT:
            begin
                sx_reg <= div_q;
                sr_reg <= 64'd0;
                sb_reg <= 64'h4000_0000_0000_0000;
            end
            OP_SQRT_STEP:
            begin
                if (sx_reg >= sq_trial)
                begin
                    sx_reg <= sx_reg - sq_trial;
                    sr_reg <= (sr_reg >> 1) + sb_reg;
                end
                else
                begin
                    sr_reg <= sr_reg >> 1;
                end
                sb_reg <= sb_reg >> 2;
            end
            OP_MUL2:
            begin
                u_reg <= 41'((57'(cp_reg) * 57'(sr_reg[31:0])) >> 16);
            end
            default:
            begin
            end
        endcase
        if (cmd.score)
        begin
            if (cmd.first || s_sat > best_reg)
            begin
                best_reg   <= s_sat;
                best_i_reg <= cmd.addr;
            end
        end
        if (cmd.emit)
        begin
            found_reg        <= 1'b1;
            chosen_child_reg <= 8'(best_i_reg);
            best_score_reg   <= best_reg;
        end
        if (cmd.empty)
        begin
            found_reg        <= 1'b0;
            chosen_child_reg <= 8'd0;
            best_score_reg   <= 32'sd0;
        end
    end

    assign found        = found_reg;
    assign chosen_child = chosen_child_reg;
    assign best_score   = best_score_reg;

    assign stat.log_top  = lt_reg[32];
    assign stat.div_done = div_done;
    assign stat.vl_zero  = (visit_new == 32'd0);
    assign stat.scan_len = (count_reg > CNT_W'(MAX_CHILDREN)) ? CNT_W'(MAX_CHILDREN)
                                                             : count_reg;

endmodule

FILE: hdl/pcs_controller.sv
// ----------------------------------------------------------------------------
// pcs_controller: sequencer of the PUCT child selector
// Steps the datapath through load, virtual loss and the selection scan.
// ----------------------------------------------------------------------------
module pcs_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          mode,
    input  pcs_pkg::dp_stat_t   stat,
    output pcs_pkg::dp_cmd_t    cmd,
    output logic                busy,
    output logic                result_strobe
);
    import pcs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_VL_READ,
        S_VL_START,
        S_VL_WAIT,
        S_EMPTY,
        S_LOG_NORM,
        S_LOG_SQ,
        S_LOG_RED,
        S_C_MUL,
        S_C_ADD,
        S_READ,
        S_SEL_START,
        S_DIV_WAIT,
        S_SQRT,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        F_MUL,
        F_SCORE,
        F_EMIT
    } fin_t;

    state_t           state_reg, state_next;
    fin_t             fin_reg, fin_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [IDX_W-1:0] child_reg, child_next;
    logic             strobe_reg, strobe_next;

    // next state and datapath command
    always_comb
    begin
        state_next  = state_reg;
        fin_next    = fin_reg;
        cnt_next    = cnt_reg;
        child_next  = child_reg;
        strobe_next = 1'b0;
        cmd         = '{op: OP_NONE, addr: child_reg, first: (child_reg == '0),
                        score: 1'b0, emit: 1'b0, empty: 1'b0};
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_CAPTURE;
                    case (mode)
                        MODE_LOAD:   state_next = S_LOAD;
                        MODE_VLOSS:  state_next = S_VL_READ;
                        MODE_SELECT: state_next = (stat.scan_len == '0) ? S_EMPTY
                                                                         : S_LOG_NORM;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.op     = OP_LOAD;
                state_next = S_IDLE;
            end
            S_VL_READ:
            begin
                cmd.op     = OP_VL_READ;
                state_next = S_VL_START;
            end
            S_VL_START:
            begin
                cmd.op     = OP_VL_START;
                state_next = stat.vl_zero ? S_IDLE : S_VL_WAIT;
            end
            S_VL_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_VL_WRITE;
                    state_next = S_IDLE;
                end
            end
            S_EMPTY:
            begin
                cmd.empty   = 1'b1;
                strobe_next = 1'b1;
                state_next  = S_IDLE;
            end
            S_LOG_NORM:
            begin
                if (stat.log_top)
                begin
                    cnt_next   = 5'd0;
                    state_next = S_LOG_SQ;
                end
                else
                begin
                    cmd.op = OP_LOG_NORM;
                end
            end
            S_LOG_SQ:
            begin
                cmd.op     = OP_LOG_SQ;
                state_next = S_LOG_RED;
            end
            S_LOG_RED:
            begin
                cmd.op     = OP_LOG_RED;
                cnt_next   = cnt_reg + 5'd1;
                state_next = (cnt_reg == 5'd15) ? S_C_MUL : S_LOG_SQ;
            end
            S_C_MUL:
            begin
                cmd.op     = OP_C_MUL;
                state_next = S_C_ADD;
            end
            S_C_ADD:
            begin
                cmd.op     = OP_C_ADD;
                child_next = '0;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.op     = OP_READ;
                state_next = S_SEL_START;
            end
            S_SEL_START:
            begin
                cmd.op     = OP_SEL_START;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_SQRT_INIT;
                    cnt_next   = 5'd0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    fin_next   = F_MUL;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                case (fin_reg)
                    F_MUL:
                    begin
                        cmd.op   = OP_MUL2;
                        fin_next = F_SCORE;
                    end
                    F_SCORE:
                    begin
                        cmd.score = 1'b1;
                        if (CNT_W'(child_reg) + CNT_W'(1) == stat.scan_len)
                        begin
                            fin_next = F_EMIT;
                        end
                        else
                        begin
                            child_next = child_reg + IDX_W'(1);
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        cmd.emit    = 1'b1;
                        strobe_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fin_reg    <= F_MUL;
            cnt_reg    <= 5'd0;
            child_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fin_reg    <= fin_next;
            cnt_reg    <= cnt_next;
            child_reg  <= child_next;
            strobe_reg <= strobe_next;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;

endmodule

FILE: test/puct_child_selector_unit_test.sv
// ----------------------------------------------------------------------------
// puct_child_selector_unit_test: self-checking bench for the child selector
// Drives load, virtual-loss and select items. A built-in predictor models the
// per-child tables and the PUCT score. Every strobed result is checked
// against the oldest predicted selection.
// ----------------------------------------------------------------------------
module puct_child_selector_unit_test;
    import pcs_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;   // unused mode, ignored
    localparam int SETTLE_CYCLES = 80;         // covers a virtual-loss item
    localparam int STALL_LIMIT   = 200000;     // cycles with nothing accepted

    typedef struct packed {
        logic              found;
        logic [7:0]        child;
        logic signed [31:0] score;
    } selection_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         mode = MODE_LOAD;
    logic [7:0]         child_index = '0;
    logic [15:0]        prior = '0;
    logic signed [31:0] total_value = '0;
    logic [7:0]         vloss_visits = '0;
    logic               result_strobe;
    logic               found;
    logic [7:0]         chosen_child;
    logic signed [31:0] best_score;
    logic               cfg_write = 1'b0;
    logic               cfg_index = CFG_EXPLORE_INIT;
    logic [15:0]        cfg_data = '0;

    // predicted node state
    logic [15:0]        node_explore;
    logic [8:0]         node_child_count;
    logic [31:0]        node_parent_visits;
    logic [31:0]        node_visits [MAX_CHILDREN];
    logic [15:0]        node_priors [MAX_CHILDREN];
    logic signed [31:0] node_totals [MAX_CHILDREN];
    logic signed [31:0] node_means  [MAX_CHILDREN];

    selection_t pending_selections [$];
    int errors = 0;
    int idle_cycles = 0;
    int burst_left = 0;

    puct_child_selector_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .child_index(child_index), .prior(prior), .total_value(total_value),
        .vloss_visits(vloss_visits), .result_strobe(result_strobe), .found(found),
        .chosen_child(chosen_child), .best_score(best_score), .cfg_write(cfg_write),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // log2 in unsigned Q16.16 by repeated squaring of a Q1.31 mantissa
    function automatic logic [31:0] log2_fixed(input longint unsigned v);
        longint unsigned t;
        longint unsigned m;
        logic [31:0] ip;
        logic [31:0] frac;
        t = v;
        ip = 0;
        frac = 0;
        while (t > 1)
        begin
            t = t >> 1;
            ip++;
        end
        if (ip >= 31)
            m = v >> (ip - 31);
        else
            m = v << (31 - ip);
        for (int k = 0; k < 16; k++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return (ip << 16) | frac;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] add_visits(input logic [31:0] a, input logic [7:0] b);
        longint unsigned s;
        s = longint'(a) + b;
        return (s > VISIT_MAX) ? VISIT_MAX : s[31:0];
    endfunction

    // PUCT scan over the children in use
    function automatic selection_t best_child();
        selection_t sel;
        int n;
        logic [31:0] la;
        logic [31:0] lb;
        longint unsigned lg;
        longint unsigned c;
        longint unsigned ratio;
        longint unsigned u;
        longint s;
        longint best;
        sel = '0;
        best = 0;
        n = (node_child_count < MAX_CHILDREN) ? node_child_count : MAX_CHILDREN;
        if (n == 0)
            return sel;
        la = log2_fixed(longint'(node_parent_visits) + 19652 + 1);
        lb = log2_fixed(19652);
        lg = (la > lb) ? (la - lb) : 0;
        c = ((lg * 45426) >> 16) + (longint'(node_explore) << 8);
        for (int i = 0; i < n; i++)
        begin
            ratio = {node_parent_visits, 32'd0} / (64'(node_visits[i]) + 64'd1);
            u = (((c * node_priors[i]) >> 16) * floor_sqrt(ratio)) >> 16;
            s = longint'(node_means[i]) + longint'(u);
            if (s > longint'(SCORE_MAX))
                s = longint'(SCORE_MAX);
            if (i == 0 || s > best)
            begin
                best = s;
                sel.child = i[7:0];
            end
        end
        sel.found = 1'b1;
        sel.score = best[31:0];
        return sel;
    endfunction

    // update the predicted node for one accepted item
    function automatic void apply_item(input logic [1:0] m, input logic [7:0] idx,
                                       input logic [15:0] p, input logic signed [31:0] av,
                                       input logic [7:0] vl);
        case (m)
            MODE_LOAD:
            begin
                node_priors[idx] = p;
                node_totals[idx] = av;
                node_visits[idx] = 0;
                node_means[idx] = 0;
                if (idx == 0)
                    node_parent_visits = 1;
            end
            MODE_VLOSS:
            begin
                node_parent_visits = add_visits(node_parent_visits, vl);
                node_visits[idx] = add_visits(node_visits[idx], vl);
                if (node_visits[idx] == 0)
                    node_means[idx] = 0;
                else
                    node_means[idx] = 32'(longint'(node_totals[idx]) /
                                          longint'(node_visits[idx]));
            end
            MODE_SELECT:
                pending_selections.push_back(best_child());
            default: ;
        endcase
    endfunction

    // send one item, with random gaps between bursts
    task automatic send_item(input logic [1:0] m, input logic [7:0] idx,
                             input logic [15:0] p, input logic signed [31:0] av,
                             input logic [7:0] vl);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                start = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        start = 1'b1;
        mode = m;
        child_index = idx;
        prior = p;
        total_value = av;
        vloss_visits = vl;
        do
            @(posedge clk);
        while (busy);
        apply_item(m, idx, p, av, vl);
    endtask

    // wait until the block is idle: results drained, last item settled
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        burst_left = 0;
        while (pending_selections.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == CFG_EXPLORE_INIT)
            node_explore = data;
        else
            node_child_count = data[8:0];
    endtask

    task automatic load_child(input logic [7:0] idx);
        send_item(MODE_LOAD, idx, 16'($urandom), 32'($urandom), 8'($urandom));
    endtask

    // extremes, every mode and the named corner cases
    task automatic test_directed();
        write_reg(CFG_CHILD_COUNT, 16'd0);
        send_item(MODE_SELECT, 8'd0, 16'd0, 32'sd0, 8'd0);       // no children
        send_item(MODE_LOAD, 8'd0, 16'hFFFF, 32'sh7FFF_FFFF, 8'hFF);
        send_item(MODE_LOAD, 8'd1, 16'h0000, -32'sh8000_0000, 8'h00);
        send_item(MODE_LOAD, 8'd2, 16'h8000, -32'sd1, 8'h00);
        send_item(MODE_LOAD, 8'd3, 16'h0001, 32'sd65536, 8'h00);
        send_item(MODE_VLOSS, 8'd1, 16'd0, 32'sd0, 8'd0);        // zero visits stay
        send_item(MODE_SELECT, 8'd0, 16'd0, 32'sd0, 8'd0);       // count still zero
        drain();
        write_reg(CFG_CHILD_COUNT, 16'd4);
        send_item(MODE_SELECT, 8'd0, 16'd0, 32'sd0, 8'd0);
        send_item(MODE_VLOSS, 8'd0, 16'd0, 32'sd0, 8'd255);
        send_item(MODE_VLOSS, 8'd2, 16'd0, 32'sd0, 8'd3);
        send_item(MODE_VLOSS, 8'd1, 16'd0, 32'sd0, 8'd7);
        send_item(MODE_SPARE, 8'hFF, 16'hFFFF, -32'sd1, 8'hFF);  // ignored
        send_item(MODE_SELECT, 8'hFF, 16'hFFFF, -32'sd1, 8'hFF);
        drain();
        write_reg(CFG_EXPLORE_INIT, 16'hFFFF);
        send_item(MODE_SELECT, 8'd0, 16'd0, 32'sd0, 8'd0);
        drain();
        write_reg(CFG_EXPLORE_INIT, 16'h0000);
        send_item(MODE_SELECT, 8'd0, 16'd0, 32'sd0, 8'd0);
        send_item(MODE_LOAD, 8'd0, 16'h1234, 32'sd1000, 8'd0);  // parent back to one
        send_item(MODE_SELECT, 8'd0, 16'd0, 32'sd0, 8'd0);
        drain();
    endtask

    // whole table in use, count at and past the table size
    task automatic test_full_table();
        write_reg(CFG_EXPLORE_INIT, 16'd640);
        for (int i = 0; i < MAX_CHILDREN; i++)
            load_child(8'(i));
        for (int i = 0; i < 6; i++)
            send_item(MODE_VLOSS, 8'($urandom_range(128, 255)), 16'($urandom),
                      32'($urandom), 8'($urandom));
        drain();
        write_reg(CFG_CHILD_COUNT, 16'd256);
        send_item(MODE_SELECT, 8'd0, 16'd0, 32'sd0, 8'd0);
        drain();
        write_reg(CFG_CHILD_COUNT, 16'd511);
        send_item(MODE_SELECT, 8'd0, 16'd0, 32'sd0, 8'd0);
        drain();
    endtask

    // short phases: fresh settings, random loads, losses and selections
    task automatic test_random_phases();
        int kids;
        int pick;
        for (int ph = 0; ph < 11; ph++)
        begin
            kids = $urandom_range(1, 10);
            case (ph % 4)
                0: write_reg(CFG_EXPLORE_INIT, 16'h0000);
                1: write_reg(CFG_EXPLORE_INIT, 16'hFFFF);
                default: write_reg(CFG_EXPLORE_INIT, 16'($urandom));
            endcase
            write_reg(CFG_CHILD_COUNT, 16'($urandom_range(0, kids)));
            for (int i = 0; i < kids; i++)
                load_child(8'(i));
            for (int k = 0; k < 24; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    load_child(8'($urandom_range(0, kids - 1)));
                else if (pick < 65)
                    send_item(MODE_VLOSS, 8'($urandom_range(0, kids - 1)), 16'($urandom),
                              32'($urandom), 8'($urandom));
                else if (pick < 95)
                    send_item(MODE_SELECT, 8'($urandom), 16'($urandom), 32'($urandom),
                              8'($urandom));
                else
                    send_item(MODE_SPARE, 8'($urandom), 16'($urandom), 32'($urandom),
                              8'($urandom));
            end
            drain();
        end
    endtask

    // compare each strobed result with the oldest prediction
    always @(posedge clk)
    begin
        selection_t want;
        if (rst_n && result_strobe)
        begin
            if (pending_selections.size() == 0)
            begin
                $display("%0t: unexpected result found=%0d child=%0d score=%0d",
                         $time, found, chosen_child, best_score);
                errors++;
            end
            else
            begin
                want = pending_selections.pop_front();
                if (found !== want.found)
                begin
                    $display("%0t: found expected %0d actual %0d", $time, want.found, found);
                    errors++;
                end
                if (chosen_child !== want.child)
                begin
                    $display("%0t: chosen_child expected %0d actual %0d",
                             $time, want.child, chosen_child);
                    errors++;
                end
                if (best_score !== want.score)
                begin
                    $display("%0t: best_score expected %0d actual %0d",
                             $time, want.score, best_score);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with neither an item nor a result accepted
    always @(posedge clk)
    begin
        if ((start && !busy) || result_strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        node_explore = 16'd640;
        node_child_count = 9'd0;
        node_parent_visits = 32'd1;
        for (int i = 0; i < MAX_CHILDREN; i++)
        begin
            node_visits[i] = 0;
            node_priors[i] = 0;
            node_totals[i] = 0;
            node_means[i] = 0;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_full_table();
        test_random_phases();
        drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
